[rtl/gtb_pkg.sv]
// ----------------------------------------------------------------------------
// gtb_pkg: shared definitions for the Gaussian to base (i-1) converter
// Sizes, controller states and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package gtb_pkg;

  // Width of each input component, read as two's complement.
  localparam int VALUE_BITS     = 24;
  // Depth of the digit store.
  localparam int MAX_DIGITS     = 64;
  // Working values need two bits of headroom over the input width.
  localparam int WORK_BITS      = VALUE_BITS + 2;
  // The digit counter must be able to hold MAX_DIGITS itself.
  localparam int COUNT_BITS     = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_BITS      = $clog2(MAX_DIGITS);
  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_BITS  = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_FETCH,
    ST_SEND
  } gtb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new input word
    logic step;     // produce one digit and update the working values
    logic fetch;    // read the most significant kept digit
    logic advance;  // read the next lower digit
  } gtb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_zero;     // both working values are zero
    logic count_full;  // the digit store is full
    logic k_zero;      // the digit on display is the least significant one
  } gtb_status_t;

endpackage

[rtl/gtb_dp.sv]
// ----------------------------------------------------------------------------
// gtb_dp: datapath of the Gaussian to base (i-1) converter
// Holds the working values, the digit store and its read register, and
// carries out one conversion step or one store read per command.
// ----------------------------------------------------------------------------
module gtb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  gtb_pkg::gtb_cmd_t                 cmd,
  output gtb_pkg::gtb_status_t              status,
  input  logic [gtb_pkg::VALUE_BITS-1:0]    real_part,
  input  logic [gtb_pkg::VALUE_BITS-1:0]    imag_part,
  output logic                              digit,
  output logic                              last_digit
);

  localparam int WB = gtb_pkg::WORK_BITS;
  localparam int VB = gtb_pkg::VALUE_BITS;
  localparam int CB = gtb_pkg::COUNT_BITS;
  localparam int AB = gtb_pkg::ADDR_BITS;

  logic [WB-1:0] work_real;
  logic [WB-1:0] work_imag;
  logic [CB-1:0] digit_count;
  logic [AB-1:0] top_idx;
  logic [AB-1:0] k_idx;
  logic          have_one;
  logic          rd_q;
  logic          digit_store [gtb_pkg::MAX_DIGITS];

  logic          r_bit;
  logic [WB+1:0] a_ext;
  logic [WB+1:0] b_ext;
  logic [WB+1:0] r_ext;
  logic [WB+1:0] sum_re;
  logic [WB+1:0] sum_im;
  logic [AB-1:0] rd_addr;
  logic [AB-1:0] wr_addr;

  // One conversion step: r = (a+b) mod 2, a' = (r-a+b)/2, b' = (r-a-b)/2.
  // Both sums are even, so dropping the low bit is an exact halving.
  always_comb begin
    r_bit  = work_real[0] ^ work_imag[0];
    a_ext  = {{2{work_real[WB-1]}}, work_real};
    b_ext  = {{2{work_imag[WB-1]}}, work_imag};
    r_ext  = {{(WB+1){1'b0}}, r_bit};
    sum_re = r_ext - a_ext + b_ext;
    sum_im = r_ext - a_ext - b_ext;
  end

  assign wr_addr = digit_count[AB-1:0];
  assign rd_addr = cmd.fetch ? top_idx : (k_idx - AB'(1));

  // Working values, digit count and the position of the highest one digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_real   <= '0;
      work_imag   <= '0;
      digit_count <= '0;
      top_idx     <= '0;
      have_one    <= 1'b0;
    end else if (cmd.load) begin
      work_real   <= {{(WB-VB){real_part[VB-1]}}, real_part};
      work_imag   <= {{(WB-VB){imag_part[VB-1]}}, imag_part};
      digit_count <= '0;
      top_idx     <= '0;
      have_one    <= 1'b0;
    end else if (cmd.step) begin
      work_real   <= sum_re[WB:1];
      work_imag   <= sum_im[WB:1];
      digit_count <= digit_count + CB'(1);
      if (r_bit) begin
        top_idx  <= wr_addr;
        have_one <= 1'b1;
      end
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      digit_store[wr_addr] <= r_bit;
    end
    if (cmd.fetch || cmd.advance) begin
      rd_q <= digit_store[rd_addr];
    end
  end

  // Index of the digit currently held in the read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_idx <= '0;
    end else if (cmd.fetch || cmd.advance) begin
      k_idx <= rd_addr;
    end
  end

  // With no one digit at all the single emitted digit is zero; this also
  // covers a zero input, where nothing was written to the store.
  assign digit      = have_one & rd_q;
  assign last_digit = (k_idx == '0);

  assign status.is_zero    = (work_real == '0) && (work_imag == '0);
  assign status.count_full = (digit_count == CB'(gtb_pkg::MAX_DIGITS));
  assign status.k_zero     = (k_idx == '0);

endmodule

[rtl/gtb_ctrl.sv]
// ----------------------------------------------------------------------------
// gtb_ctrl: controller of the Gaussian to base (i-1) converter
// Sequences capture, digit generation and most-significant-first output,
// and drives both stream handshakes.
// ----------------------------------------------------------------------------
module gtb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gtb_pkg::gtb_status_t status,
  output gtb_pkg::gtb_cmd_t    cmd
);

  gtb_pkg::gtb_state_t state;
  gtb_pkg::gtb_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      gtb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gtb_pkg::ST_GEN;
        end
      end
      gtb_pkg::ST_GEN: begin
        if (status.is_zero || status.count_full) begin
          state_next = gtb_pkg::ST_FETCH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      gtb_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = gtb_pkg::ST_SEND;
      end
      gtb_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.k_zero) begin
            state_next = gtb_pkg::ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = gtb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/gaussian_to_base_i_minus_1_core.sv]
// ----------------------------------------------------------------------------
// gaussian_to_base_i_minus_1_core: Gaussian integer to base (i-1) digits
// Converts a + b*i to its complex base (i-1) digit string and streams the
// digits out most significant first.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one Gaussian integer per word. The output stream
// carries one digit per word, most significant first, leading zeros
// stripped; tlast marks the least significant digit. A zero input gives a
// single digit 0 with tlast.
// Timing: after a word is accepted the block generates its n digits (one
// conversion step per cycle, n is never more than 64), reads the top digit
// from the store, and then presents one digit per cycle while the receiver
// keeps tready high. The single-port read of the digit store sets the
// output pace.
// One item is processed at a time: s_tready is high only while idle.
// When the receiver stalls, the current digit and tlast hold until taken.
// Reset returns the block to idle with no output pending; the digit store
// needs no clearing.
// ----------------------------------------------------------------------------
module gaussian_to_base_i_minus_1_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input word: real_part [23:0], imag_part [47:24].
  input  logic [gtb_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Output word: digit [0], zero padding above.
  output logic [gtb_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready
);

  localparam int VB = gtb_pkg::VALUE_BITS;

  gtb_pkg::gtb_cmd_t    cmd;
  gtb_pkg::gtb_status_t status;
  logic                 digit;
  logic                 last_digit;

  gtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gtb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .real_part  (s_tdata[VB-1:0]),
    .imag_part  (s_tdata[2*VB-1:VB]),
    .digit      (digit),
    .last_digit (last_digit)
  );

  assign m_tdata = {{(gtb_pkg::OUT_TDATA_BITS-1){1'b0}}, digit};
  assign m_tlast = last_digit;

`ifndef SYNTH
  // The block never takes a new word while a digit is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // An accepted word keeps the input closed in the next cycle.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready after accepting a word");

  // Delivering the final digit returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after final digit");

  // The first digit of a run is a one unless it is the only digit.
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && !m_tlast) |-> m_tdata[0])
    else $error("leading zero digit emitted");
`endif

endmodule

[bench/gaussian_to_base_i_minus_1_core_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_to_base_i_minus_1_core_tb: self-checking bench for the converter
// Feeds Gaussian integers into the input stream and checks every output
// digit word against a behavioral predictor of the base (i-1) expansion.
// The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gaussian_to_base_i_minus_1_core_tb;

  localparam int VB = gtb_pkg::VALUE_BITS;
  localparam int MD = gtb_pkg::MAX_DIGITS;
  localparam int IB = gtb_pkg::IN_TDATA_BITS;
  localparam int OB = gtb_pkg::OUT_TDATA_BITS;

  // One expected output word: the digit and its tlast flag.
  typedef struct packed {
    logic digit;
    logic last;
  } gtb_digit_t;

  localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic [IB-1:0]  s_tdata = '0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [OB-1:0]  m_tdata;
  logic           m_tlast;
  logic           m_tvalid;
  logic           m_tready = 1'b0;

  gtb_digit_t pending_digits[$];
  int         mismatch_count = 0;
  int         numbers_sent = 0;
  int         digits_checked = 0;
  int         burst_left = 0;
  bit         rx_always_ready = 1'b0;

  gaussian_to_base_i_minus_1_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),   // real_part [23:0], imag_part [47:24]
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),   // digit [0], zero padding above
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always #5 clk = ~clk;

  // Expand a + b*i into base (i-1) digits and queue the expected words,
  // most significant first, with leading zeros dropped.
  function automatic void predict_digits(input logic signed [VB-1:0] re,
                                         input logic signed [VB-1:0] im);
    longint        wr;
    longint        wi;
    longint        r;
    longint        na;
    logic [MD-1:0] store;
    int            cnt;
    int            top;
    gtb_digit_t    d;
    wr = re;
    wi = im;
    store = '0;
    cnt = 0;
    while ((wr != 0 || wi != 0) && cnt < MD) begin
      r = (wr + wi) & 64'sd1;
      na = (r - wr + wi) / 2;
      wi = (r - wr - wi) / 2;
      wr = na;
      store[cnt] = r[0];
      cnt++;
    end
    top = cnt - 1;
    while (top > 0 && store[top] == 1'b0) top--;
    if (top < 0) begin
      // A zero input still produces one word: digit 0 with tlast.
      d.digit = 1'b0;
      d.last = 1'b1;
      pending_digits.push_back(d);
    end else begin
      for (int k = top; k >= 0; k--) begin
        d.digit = store[k];
        d.last = (k == 0);
        pending_digits.push_back(d);
      end
    end
  endfunction

  // Present one number and hold it until the block takes the word.
  // Valid is left high; the pacing task lowers it for a gap.
  task automatic send_gaussian(input logic signed [VB-1:0] re,
                               input logic signed [VB-1:0] im);
    logic [IB-1:0] w;
    w = '0;
    w[VB-1:0] = re;
    w[2*VB-1:VB] = im;
    s_tdata <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_digits(re, im);
    numbers_sent++;
  endtask

  // Burst pacing: after a burst runs out, drop valid for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 20);
      burst_left = $urandom_range(0, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [VB-1:0] rand_full();
    return VB'($urandom());
  endfunction

  // Receiver stall pattern: it switches between modes at random, from always
  // ready to rare single-cycle acceptance.
  int rx_left = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  always @(posedge clk) begin : rx_pattern
    logic rdy;
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 1) == 1);
      2: rdy = ($urandom_range(0, 7) == 0);
      default: rdy = ((rx_phase % 7) < 4);
    endcase
    if (rx_always_ready) rdy = 1'b1;
    m_tready <= rdy;
  end

  // Compare each accepted digit word with the oldest expectation.
  always @(posedge clk) begin : digit_checker
    gtb_digit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit word: expected none, actual tdata=%0h tlast=%0b",
                 $time, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        if (m_tdata !== {{(OB-1){1'b0}}, want.digit}) begin
          $display("%0t: digit mismatch: expected tdata=%0h actual tdata=%0h",
                   $time, {{(OB-1){1'b0}}, want.digit}, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: tlast mismatch: expected %0b actual %0b",
                   $time, want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Zero, units, extremes and a few fixed patterns.
  task automatic test_directed();
    logic signed [VB-1:0] re_list[20];
    logic signed [VB-1:0] im_list[20];
    re_list = '{24'sd0, 24'sd1, 24'sd0, -24'sd1, 24'sd0, 24'sd1, -24'sd1, VAL_MAX,
                VAL_MIN, 24'sd0, 24'sd0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 24'sd2,
                -24'sd5, 24'sh400000, 24'sh555555, 24'shAAAAAA};
    im_list = '{24'sd0, 24'sd0, 24'sd1, 24'sd0, -24'sd1, 24'sd1, -24'sd1, 24'sd0,
                24'sd0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, -24'sd3,
                24'sd7, 24'shC00000, 24'shAAAAAA, 24'sh555555};
    for (int i = 0; i < 20; i++) begin
      send_gaussian(re_list[i], im_list[i]);
      pace_sender();
    end
  endtask

  // Uniform values over the whole signed range.
  task automatic test_random_full(input int count);
    for (int i = 0; i < count; i++) begin
      send_gaussian(rand_full(), rand_full());
      pace_sender();
    end
  endtask

  // Small magnitudes give short digit strings and many zeros.
  task automatic test_random_small(input int count);
    int re;
    int im;
    for (int i = 0; i < count; i++) begin
      re = $urandom_range(0, 128);
      im = $urandom_range(0, 128);
      send_gaussian(VB'(re - 64), VB'(im - 64));
      pace_sender();
    end
  endtask

  // Powers of two with small offsets, and values close to the extremes.
  task automatic test_random_edges(input int count);
    logic signed [VB-1:0] v[2];
    int off;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 2; j++) begin
        off = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: v[j] = VB'((1 << $urandom_range(0, VB - 2)) + off - 3);
          1: v[j] = VB'(-(1 << $urandom_range(0, VB - 2)) + off - 3);
          2: v[j] = VB'(VAL_MAX - off);
          default: v[j] = VB'(VAL_MIN + off);
        endcase
      end
      send_gaussian(v[0], v[1]);
      pace_sender();
    end
  endtask

  // Full-rate stretch: no sender gaps and no receiver stalls.
  task automatic test_back_to_back(input int count);
    rx_always_ready = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_gaussian(rand_full(), rand_full());
    end
    rx_always_ready = 1'b0;
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("Timeout with %0d digit words still expected.", pending_digits.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_full(90);
    test_random_small(70);
    test_random_edges(60);
    test_back_to_back(30);

    s_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Converted %0d Gaussian integers and checked %0d digit words.",
             numbers_sent, digits_checked);
    $display("Covered zero, units, range extremes, small and full-range values.");
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gtb_pkg.sv
rtl/gtb_dp.sv
rtl/gtb_ctrl.sv
rtl/gaussian_to_base_i_minus_1_core.sv
bench/gaussian_to_base_i_minus_1_core_tb.sv
